FILE: src/crr_pkg.sv
// Shared types, constants and arithmetic helpers of the binomial tree option pricer.
package crr_pkg;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CFG_UP_FACTOR   = 3'd0,
    CFG_DOWN_FACTOR = 3'd1,
    CFG_WEIGHT_UP   = 3'd2,
    CFG_WEIGHT_DOWN = 3'd3,
    CFG_STRIKE      = 3'd4,
    CFG_IS_PUT      = 3'd5,
    CFG_IS_AMERICAN = 3'd6,
    CFG_STEP_COUNT  = 3'd7
  } cfg_idx_e;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_BASE   = 8'b0000_0010,
    ST_WDIV   = 8'b0000_0100,
    ST_TERM   = 8'b0000_1000,
    ST_LSTART = 8'b0001_0000,
    ST_NODE   = 8'b0010_0000,
    ST_DRAIN  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [31:0] weight_up;
    logic [31:0] weight_down;
    logic [31:0] strike;
    logic        is_put;
    logic        is_american;
  } bl_cfg_t;

  function automatic logic [31:0] mul_q28(input logic [31:0] a, input logic [31:0] f);
    logic [63:0] p;
    p = {32'b0, a} * {32'b0, f};
    return (p[63:60] != 4'b0) ? SAT32 : p[59:28];
  endfunction

  function automatic logic [31:0] payoff(input logic [31:0] price, input logic [31:0] strike,
                                         input logic is_put);
    logic [31:0] r;
    r = 32'b0;
    if (is_put) begin
      if (strike > price) r = strike - price;
    end else begin
      if (price > strike) r = price - strike;
    end
    return r;
  endfunction

  function automatic logic [31:0] blend_sum(input logic [63:0] pu, input logic [63:0] pd);
    logic [64:0] s;
    s = {1'b0, pu} + {1'b0, pd};
    return (s[64] || s[63]) ? SAT32 : s[62:31];
  endfunction

endpackage

FILE: src/crr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module crr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/crr_div.sv
// Bit-serial restoring divider that forms the saturated Q4.28 ratio of up over down.
module crr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] up_i,
  input  logic [31:0] down_i,
  output logic        busy_o,
  output logic [31:0] quot_o
);

  localparam logic [5:0] DIV_STEPS = 6'd60;

  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] num_q, num_d;
  logic [31:0] div_q, div_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic        ovf_q, ovf_d;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {rem_q, num_q[31]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = ge ? (trial - {1'b0, div_q}) : trial;

  always_comb begin
    cnt_d = cnt_q;
    num_d = num_q;
    div_d = div_q;
    rem_d = rem_q;
    quo_d = quo_q;
    ovf_d = ovf_q;
    if (start_i) begin
      cnt_d = DIV_STEPS;
      num_d = up_i;
      div_d = down_i;
      rem_d = 32'b0;
      quo_d = 32'b0;
      ovf_d = 1'b0;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      num_d = {num_q[30:0], 1'b0};
      rem_d = diff[31:0];
      quo_d = {quo_q[30:0], ge};
      ovf_d = ovf_q | quo_q[31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign busy_o = cnt_q != 6'd0;
  assign quot_o = ovf_q ? crr_pkg::SAT32 : quo_q;

endmodule

FILE: src/crr_blend.sv
// Node update pipeline: weighted blend of two child values with the early-exercise check.
module crr_blend #(
  parameter int AW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  crr_pkg::bl_cfg_t cfg_i,
  input  logic             iss_vld_i,
  input  logic [AW-1:0]    iss_addr_i,
  input  logic [31:0]      iss_price_i,
  input  logic [31:0]      rd_data_i,
  output logic             wr_vld_o,
  output logic [AW-1:0]    wr_addr_o,
  output logic [31:0]      wr_data_o,
  output logic             busy_o
);

  logic          s1_vld_q;
  logic [AW-1:0] s1_addr_q;
  logic [31:0]   s1_price_q;
  logic [31:0]   hold_q;
  logic          s2_vld_q;
  logic [AW-1:0] s2_addr_q;
  logic [63:0]   s2_up_q;
  logic [63:0]   s2_dn_q;
  logic [31:0]   s2_ex_q;
  logic [31:0]   cont;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= iss_vld_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  // The previously read value is the lower child of the node now in the first stage.
  always_ff @(posedge clk_i) begin
    s1_addr_q  <= iss_addr_i;
    s1_price_q <= iss_price_i;
    hold_q     <= rd_data_i;
    s2_addr_q  <= s1_addr_q;
    s2_up_q    <= {32'b0, rd_data_i} * {32'b0, cfg_i.weight_up};
    s2_dn_q    <= {32'b0, hold_q} * {32'b0, cfg_i.weight_down};
    s2_ex_q    <= crr_pkg::payoff(s1_price_q, cfg_i.strike, cfg_i.is_put);
  end

  assign cont      = crr_pkg::blend_sum(s2_up_q, s2_dn_q);
  assign wr_vld_o  = s2_vld_q;
  assign wr_addr_o = s2_addr_q;
  assign wr_data_o = (cfg_i.is_american && (s2_ex_q > cont)) ? s2_ex_q : cont;
  assign busy_o    = s1_vld_q;

endmodule

FILE: src/binomial_tree_option_pricer.sv
// Top level of the binomial tree option pricer: configuration, sequencer and memories.
// Each spot price is priced on its own over n steps (n clamped to MAX_NODES-1); the terminal
// pass waits on the serial divider that forms the up-over-down ratio. The backward induction
// then updates one node per cycle through the single read and single write port of the
// option-value memory and drains its update pipeline at the end of every level. The next
// request is taken once the previous result has been placed in the output register; no
// memory clearing is needed after reset.
module binomial_tree_option_pricer #(
  parameter int MAX_NODES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] spot_price_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] option_value_o
);

  localparam int AW = $clog2(MAX_NODES);
  localparam logic [AW-1:0] NMAX = AW'(MAX_NODES - 1);

  logic [31:0] up_q, down_q, wup_q, wdn_q, strike_q;
  logic        put_q, amer_q;
  logic [9:0]  step_q;

  crr_pkg::state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] lvl_q, lvl_d;
  logic [AW-1:0] n_q, n_d;
  logic [AW-1:0] n_clamp;
  logic [31:0]   price_q, price_d;
  logic [31:0]   res_q;
  logic [31:0]   out_q;
  logic          out_vld_q;
  logic          out_load;
  logic          div_start;
  logic          div_busy;
  logic [31:0]   ratio;
  logic [31:0]   mul_a, mul_f, mul_res;
  logic          iss_vld;

  logic          np_we;
  logic [31:0]   np_rdata;
  logic          ov_we;
  logic [AW-1:0] ov_waddr, ov_raddr;
  logic [31:0]   ov_wdata, ov_rdata;
  logic          bl_wr_vld;
  logic [AW-1:0] bl_wr_addr;
  logic [31:0]   bl_wr_data;
  logic          bl_busy;
  crr_pkg::bl_cfg_t bl_cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q     <= 32'd268435456;
      down_q   <= 32'd268435456;
      wup_q    <= 32'd1073741824;
      wdn_q    <= 32'd1073741824;
      strike_q <= 32'd0;
      put_q    <= 1'b0;
      amer_q   <= 1'b0;
      step_q   <= 10'd64;
    end else if (cfg_we_i) begin
      unique case (crr_pkg::cfg_idx_e'(cfg_idx_i))
        crr_pkg::CFG_UP_FACTOR:   up_q     <= cfg_data_i;
        crr_pkg::CFG_DOWN_FACTOR: down_q   <= cfg_data_i;
        crr_pkg::CFG_WEIGHT_UP:   wup_q    <= cfg_data_i;
        crr_pkg::CFG_WEIGHT_DOWN: wdn_q    <= cfg_data_i;
        crr_pkg::CFG_STRIKE:      strike_q <= cfg_data_i;
        crr_pkg::CFG_IS_PUT:      put_q    <= cfg_data_i[0];
        crr_pkg::CFG_IS_AMERICAN: amer_q   <= cfg_data_i[0];
        crr_pkg::CFG_STEP_COUNT:  step_q   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign bl_cfg = '{weight_up: wup_q, weight_down: wdn_q, strike: strike_q,
                    is_put: put_q, is_american: amer_q};

  assign n_clamp = ({22'b0, step_q} > 32'(MAX_NODES - 1)) ? NMAX : AW'(step_q);

  assign mul_a   = (state_q == crr_pkg::ST_NODE && cnt_q == '0) ? np_rdata : price_q;
  assign mul_f   = (state_q == crr_pkg::ST_BASE) ? down_q : ratio;
  assign mul_res = crr_pkg::mul_q28(mul_a, mul_f);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    lvl_d     = lvl_q;
    n_d       = n_q;
    price_d   = price_q;
    div_start = 1'b0;
    iss_vld   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      crr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d   = crr_pkg::ST_BASE;
          price_d   = spot_price_i;
          cnt_d     = '0;
          n_d       = n_clamp;
          div_start = 1'b1;
        end
      end
      crr_pkg::ST_BASE: begin
        if (cnt_q == n_q) begin
          cnt_d   = '0;
          state_d = crr_pkg::ST_WDIV;
        end else begin
          cnt_d   = cnt_q + AW'(1);
          price_d = mul_res;
        end
      end
      crr_pkg::ST_WDIV: begin
        if (!div_busy) state_d = crr_pkg::ST_TERM;
      end
      crr_pkg::ST_TERM: begin
        price_d = mul_res;
        if (cnt_q == n_q) begin
          cnt_d = '0;
          if (n_q == '0) begin
            state_d = crr_pkg::ST_DONE;
          end else begin
            lvl_d   = n_q - AW'(1);
            state_d = crr_pkg::ST_LSTART;
          end
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      crr_pkg::ST_LSTART: begin
        cnt_d   = '0;
        state_d = crr_pkg::ST_NODE;
      end
      crr_pkg::ST_NODE: begin
        iss_vld = 1'b1;
        price_d = mul_res;
        if (cnt_q == lvl_q) begin
          state_d = crr_pkg::ST_DRAIN;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      crr_pkg::ST_DRAIN: begin
        if (!bl_busy) begin
          if (lvl_q == '0) begin
            state_d = crr_pkg::ST_DONE;
          end else begin
            lvl_d   = lvl_q - AW'(1);
            state_d = crr_pkg::ST_LSTART;
          end
        end
      end
      crr_pkg::ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = crr_pkg::ST_IDLE;
        end
      end
      default: state_d = crr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= crr_pkg::ST_IDLE;
      cnt_q     <= '0;
      lvl_q     <= '0;
      n_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lvl_q   <= lvl_d;
      n_q     <= n_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // The last value written to the root entry is the price of the option.
  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    if (ov_we && ov_waddr == '0) begin
      res_q <= ov_wdata;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign np_we    = state_q == crr_pkg::ST_BASE;
  assign ov_we    = (state_q == crr_pkg::ST_TERM) || bl_wr_vld;
  assign ov_waddr = (state_q == crr_pkg::ST_TERM) ? cnt_q : bl_wr_addr;
  assign ov_wdata = (state_q == crr_pkg::ST_TERM) ?
                    crr_pkg::payoff(price_q, strike_q, put_q) : bl_wr_data;
  assign ov_raddr = (state_q == crr_pkg::ST_LSTART) ? '0 : cnt_q + AW'(1);

  crr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .up_i    (up_q),
    .down_i  (down_q),
    .busy_o  (div_busy),
    .quot_o  (ratio)
  );

  crr_ram #(
    .WIDTH (32),
    .DEPTH (MAX_NODES)
  ) u_np_ram (
    .clk_i   (clk_i),
    .we_i    (np_we),
    .waddr_i (cnt_q),
    .wdata_i (price_q),
    .raddr_i (lvl_q),
    .rdata_o (np_rdata)
  );

  crr_ram #(
    .WIDTH (32),
    .DEPTH (MAX_NODES)
  ) u_ov_ram (
    .clk_i   (clk_i),
    .we_i    (ov_we),
    .waddr_i (ov_waddr),
    .wdata_i (ov_wdata),
    .raddr_i (ov_raddr),
    .rdata_o (ov_rdata)
  );

  crr_blend #(
    .AW (AW)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (bl_cfg),
    .iss_vld_i   (iss_vld),
    .iss_addr_i  (cnt_q),
    .iss_price_i (mul_a),
    .rd_data_i   (ov_rdata),
    .wr_vld_o    (bl_wr_vld),
    .wr_addr_o   (bl_wr_addr),
    .wr_data_o   (bl_wr_data),
    .busy_o      (bl_busy)
  );

  assign in_ready_o     = state_q == crr_pkg::ST_IDLE;
  assign out_valid_o    = out_vld_q;
  assign option_value_o = out_q;

endmodule

FILE: src/crr_chk.sv
// Port-level checker for the binomial tree option pricer and its bind statement.
module crr_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] option_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(option_value_o))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new request taken while pricing");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a pricing pass");

endmodule

bind binomial_tree_option_pricer crr_chk u_crr_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .option_value_o (option_value_o)
);

FILE: dv/crr_price_checker.sv
// Checker for the binomial tree option pricer: tracks configuration, predicts root values and compares.
`timescale 1ns / 100ps
module crr_price_checker
  import crr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] spot_price_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] option_value_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int TREE_NODES = 1024;

  typedef struct packed {
    logic [31:0] spot;
    logic [31:0] value;
  } quote_t;

  logic [31:0] up_q     = 32'h1000_0000;
  logic [31:0] down_q   = 32'h1000_0000;
  logic [31:0] wu_q     = 32'h4000_0000;
  logic [31:0] wd_q     = 32'h4000_0000;
  logic [31:0] strike_q = 32'h0;
  logic        put_q    = 1'b0;
  logic        amer_q   = 1'b0;
  logic [9:0]  steps_q  = 10'd64;

  logic [31:0] level_base [TREE_NODES];
  logic [31:0] node_value [TREE_NODES];

  quote_t      quote_q [$];
  quote_t      quote;
  int unsigned fail_cnt = 0;

  function automatic logic [31:0] clip_u32(input logic [64:0] v);
    return (v > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] scale_q28(input logic [31:0] a, input logic [31:0] f);
    logic [63:0] p;
    p = 64'(a) * 64'(f);
    return clip_u32({1'b0, p >> 28});
  endfunction

  function automatic logic [31:0] exercise_value(input logic [31:0] price);
    if (put_q) return (strike_q > price) ? strike_q - price : 32'h0;
    return (price > strike_q) ? price - strike_q : 32'h0;
  endfunction

  function automatic logic [31:0] discount_blend(input logic [31:0] v_up, input logic [31:0] v_dn);
    logic [64:0] s;
    s = {1'b0, 64'(wu_q) * 64'(v_up)} + {1'b0, 64'(wd_q) * 64'(v_dn)};
    return clip_u32(s >> 31);
  endfunction

  function automatic logic [31:0] price_option(input logic [31:0] spot);
    int          n;
    logic [63:0] quot;
    logic [31:0] ratio;
    logic [31:0] price;
    logic [31:0] held;
    logic [31:0] early;
    n = int'(steps_q);
    if (down_q == 32'h0) begin
      ratio = 32'hFFFF_FFFF;
    end else begin
      quot = {4'b0, up_q, 28'b0} / 64'(down_q);
      ratio = clip_u32({1'b0, quot});
    end
    level_base[0] = spot;
    for (int k = 1; k <= n; k++) level_base[k] = scale_q28(level_base[k-1], down_q);
    price = level_base[n];
    for (int i = 0; i <= n; i++) begin
      node_value[i] = exercise_value(price);
      price = scale_q28(price, ratio);
    end
    for (int lvl = n - 1; lvl >= 0; lvl--) begin
      price = level_base[lvl];
      for (int j = 0; j <= lvl; j++) begin
        held = discount_blend(node_value[j+1], node_value[j]);
        if (amer_q) begin
          early = exercise_value(price);
          if (early > held) held = early;
        end
        node_value[j] = held;
        price = scale_q28(price, ratio);
      end
    end
    return node_value[0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q     = 32'h1000_0000;
      down_q   = 32'h1000_0000;
      wu_q     = 32'h4000_0000;
      wd_q     = 32'h4000_0000;
      strike_q = 32'h0;
      put_q    = 1'b0;
      amer_q   = 1'b0;
      steps_q  = 10'd64;
      quote_q.delete();
      pending_o    <= 0;
      fail_count_o <= fail_cnt;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_UP_FACTOR:   up_q     = cfg_data_i;
          CFG_DOWN_FACTOR: down_q   = cfg_data_i;
          CFG_WEIGHT_UP:   wu_q     = cfg_data_i;
          CFG_WEIGHT_DOWN: wd_q     = cfg_data_i;
          CFG_STRIKE:      strike_q = cfg_data_i;
          CFG_IS_PUT:      put_q    = cfg_data_i[0];
          CFG_IS_AMERICAN: amer_q   = cfg_data_i[0];
          CFG_STEP_COUNT:  steps_q  = cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        quote.spot  = spot_price_i;
        quote.value = price_option(spot_price_i);
        quote_q.push_back(quote);
      end
      if (out_valid_i && out_ready_i) begin
        if (quote_q.size() == 0) begin
          if (fail_cnt < 10) begin
            $display("Option value %h arrived with no request outstanding.", option_value_i);
          end
          fail_cnt++;
        end else begin
          quote = quote_q.pop_front();
          if (option_value_i !== quote.value) begin
            if (fail_cnt < 10) begin
              $display("Option value mismatch for spot %h: expected %h, got %h.",
                       quote.spot, quote.value, option_value_i);
            end
            fail_cnt++;
          end
        end
      end
      pending_o    <= quote_q.size();
      fail_count_o <= fail_cnt;
    end
  end

endmodule

FILE: dv/tb_binomial_tree_option_pricer.sv
// Testbench top for the binomial tree option pricer: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb_binomial_tree_option_pricer;
  import crr_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 80;
  localparam logic [31:0] ONE_Q28      = 32'h1000_0000;
  localparam logic [31:0] HALF_Q31     = 32'h4000_0000;
  localparam logic [31:0] K_100        = 32'h0064_0000;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [2:0]  cfg_idx_i      = 3'b0;
  logic [31:0] cfg_data_i     = 32'h0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [31:0] spot_price_i   = 32'h0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [31:0] option_value_o;

  logic        stall_en       = 1'b1;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles   = 0;

  binomial_tree_option_pricer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .spot_price_i   (spot_price_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .option_value_o (option_value_o)
  );

  crr_price_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .spot_price_i   (spot_price_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .option_value_i (option_value_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!stall_en) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] inverse_q28(input logic [31:0] u);
    logic [63:0] q;
    q = 64'h0100_0000_0000_0000 / 64'(u);
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(3))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return ONE_Q28;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_spot(input logic [31:0] k);
    if ($urandom_range(99) < 25 || k < 32'h10) return $urandom();
    return k - (k >> 2) + ($urandom() % ((k >> 1) | 32'h1));
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_setting(input logic [31:0] up, input logic [31:0] down,
                              input logic [31:0] wup, input logic [31:0] wdn,
                              input logic [31:0] k, input logic put, input logic amer,
                              input logic [9:0] steps);
    write_reg(CFG_UP_FACTOR, up);
    write_reg(CFG_DOWN_FACTOR, down);
    write_reg(CFG_WEIGHT_UP, wup);
    write_reg(CFG_WEIGHT_DOWN, wdn);
    write_reg(CFG_STRIKE, k);
    write_reg(CFG_IS_PUT, ($urandom() & 32'hFFFF_FFFE) | 32'(put));
    write_reg(CFG_IS_AMERICAN, ($urandom() & 32'hFFFF_FFFE) | 32'(amer));
    write_reg(CFG_STEP_COUNT, ($urandom() & 32'hFFFF_FC00) | 32'(steps));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_spot(input logic [31:0] spot);
    while (stall_en && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    spot_price_i <= spot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] up_f;
    logic [31:0] down_f;
    logic [31:0] w_up;
    logic [31:0] w_dn;
    logic [31:0] strike_v;
    logic [9:0]  steps;
    int unsigned sent_random;
    sent_random = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_spot(32'h0);
    send_spot(32'hFFFF_FFFF);
    send_spot(K_100);

    wait_idle();
    load_setting(32'h1199_999A, inverse_q28(32'h1199_999A), 32'h3F5C_28F6, 32'h3FAE_147B,
                 K_100, 1'b1, 1'b1, 10'd8);
    send_spot(32'h0);
    send_spot(32'h1);
    send_spot(32'h005A_0000);
    send_spot(K_100);
    send_spot(32'h006E_0000);
    send_spot(32'hFFFF_FFFF);

    wait_idle();
    load_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h0, 1'b0, 1'b0, 10'd1);
    send_spot(32'hFFFF_FFFF);
    send_spot(32'h0);
    send_spot(32'h0001_0000);

    wait_idle();
    load_setting(32'h2000_0000, 32'h0, 32'h8000_0000, 32'h8000_0000,
                 32'hFFFF_FFFF, 1'b1, 1'b1, 10'd5);
    send_spot(32'h0);
    send_spot(32'hFFFF_FFFF);
    send_spot(32'h1234_5678);

    wait_idle();
    load_setting(32'h0, ONE_Q28, 32'h0, 32'h0, K_100, 1'b0, 1'b0, 10'd0);
    send_spot(32'h00C8_0000);
    send_spot(32'h0010_0000);

    wait_idle();
    load_setting(32'h1028_F5C3, inverse_q28(32'h1028_F5C3), 32'h3FE0_0000, 32'h3FE0_0000,
                 K_100, 1'b1, 1'b1, 10'd1023);
    send_spot(32'h0060_0000);

    while (sent_random < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(3))
        0, 1: begin
          up_f     = ONE_Q28 + $urandom_range(32'h0400_0000, 1);
          down_f   = inverse_q28(up_f);
          w_up     = $urandom_range(32'h4800_0000, 32'h3000_0000);
          w_dn     = 32'h7F80_0000 - w_up;
          strike_v = $urandom_range(32'h0800_0000, 32'h0001_0000);
        end
        2: begin
          up_f     = $urandom();
          down_f   = $urandom();
          w_up     = $urandom();
          w_dn     = $urandom();
          strike_v = $urandom();
        end
        default: begin
          up_f     = edge_word();
          down_f   = edge_word();
          w_up     = edge_word();
          w_dn     = edge_word();
          strike_v = edge_word();
        end
      endcase
      if ($urandom_range(19) == 0) begin
        steps = 10'($urandom_range(40));
      end else begin
        steps = 10'($urandom_range(16, 1));
      end
      load_setting(up_f, down_f, w_up, w_dn, strike_v, 1'($urandom_range(1)),
                   1'($urandom_range(1)), steps);
      repeat ($urandom_range(14, 6)) begin
        stall_en <= !(sent_random >= 30 && sent_random < 60);
        send_spot(pick_spot(strike_v));
        sent_random++;
      end
    end

    wait_idle();
    repeat (1000) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
